/* sv/wrpc_pkg.sv */
package wrpc_pkg;

  localparam int RULE_SLOTS_DEF = 16;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 16;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam int WILD_SRC   = 0;
  localparam int WILD_DST   = 1;
  localparam int WILD_PROTO = 2;
  localparam int WILD_APP   = 3;
  localparam int WILD_SPORT = 4;
  localparam int WILD_DPORT = 5;

  localparam logic [1:0] ST_CLASSIFIED = 2'd0;
  localparam logic [1:0] ST_ADDED      = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_APPEND   = 1'b1;

  typedef enum logic [1:0] {
    RES_ADDED,
    RES_FULL,
    RES_PASS,
    RES_HIT
  } res_sel_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] app_type;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  code_point;
    logic [5:0]  wild_mask;
    logic        is_ipv4;
    logic        app_tagged;
    logic        ports_present;
  } item_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] app_type;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  dscp;
    logic [5:0]  wild_mask;
  } rule_t;

  typedef struct packed {
    logic     load;
    logic     write;
    logic     issue;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_append;
    logic full;
    logic is_ipv4;
    logic scan_end;
    logic pending;
    logic hit;
  } dp_stat_t;

endpackage

/* sv/wildcard_rule_packet_classifier_unit.sv */
// First-match rule classifier. An append transfer (tuser 1) stores one marking
// rule in the next free slot of the rule memory and answers with its slot, or
// with table full. A classify transfer (tuser 0) is compared against the
// stored rules in insertion order and the first matching rule supplies the
// DSCP; with no match the packet's own DSCP passes, and non-IPv4 gets 0. One
// item is handled at a time. An append or a non-IPv4 packet is answered
// without a scan. A classify reads the stored rules one per cycle through the
// single registered read port of the rule memory and stops at the first match
// or after the last stored rule. A finished result waits in the output
// register while the next item is taken in.
module wildcard_rule_packet_classifier_unit import wrpc_pkg::*; #(
  parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // src_addr, dst_addr, protocol, app_type, src_port, dst_port,
  // code_point, wild_mask, is_ipv4, app_tagged, ports_present, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // cmd
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // result_dscp, matched, rule_index, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [1:0]             m_tuser
);

  item_t      item_in;
  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  logic [1:0] out_status;
  logic [5:0] out_dscp;
  logic       out_matched;
  logic [3:0] out_index;

  always_comb begin
    item_in.cmd           = s_tuser;
    item_in.src_addr      = s_tdata[31:0];
    item_in.dst_addr      = s_tdata[63:32];
    item_in.protocol      = s_tdata[71:64];
    item_in.app_type      = s_tdata[87:72];
    item_in.src_port      = s_tdata[103:88];
    item_in.dst_port      = s_tdata[119:104];
    item_in.code_point    = s_tdata[125:120];
    item_in.wild_mask     = s_tdata[131:126];
    item_in.is_ipv4       = s_tdata[132];
    item_in.app_tagged    = s_tdata[133];
    item_in.ports_present = s_tdata[134];
  end

  wrpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wrpc_datapath #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item_in     (item_in),
    .cmd         (cmd),
    .stat        (stat),
    .out_status  (out_status),
    .out_dscp    (out_dscp),
    .out_matched (out_matched),
    .out_index   (out_index)
  );

  assign m_tuser = out_status;
  assign m_tdata = {5'd0, out_index, out_matched, out_dscp};

endmodule

/* sv/wrpc_ctrl.sv */
module wrpc_ctrl import wrpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_sel  = RES_PASS;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_append) begin
          cmd.write    = !stat.full;
          cmd.res_load = 1'b1;
          cmd.res_sel  = stat.full ? RES_FULL : RES_ADDED;
          state_next   = S_RESULT;
        end else if (!stat.is_ipv4) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PASS;
          state_next   = S_RESULT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_HIT;
          state_next   = S_RESULT;
        end else if (stat.scan_end && !stat.pending) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PASS;
          state_next   = S_RESULT;
        end else begin
          cmd.issue = !stat.scan_end;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/wrpc_datapath.sv */
module wrpc_datapath import wrpc_pkg::*; #(
  parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item_in,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  output logic [1:0]  out_status,
  output logic [5:0]  out_dscp,
  output logic        out_matched,
  output logic [3:0]  out_index
);

  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W = $clog2(RULE_SLOTS + 1);
  localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

  item_t            item;
  rule_t            mem [RULE_SLOTS];
  rule_t            rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;

  logic [1:0]       res_status;
  logic [5:0]       res_dscp;
  logic             res_hit;
  logic [IDX_W-1:0] res_idx;
  logic [EXT_W-1:0] res_idx_ext;

  logic             ports_ok;
  logic             match;
  rule_t            wr_rule;

  assign ports_ok = item.ports_present && (item.protocol inside {PROTO_TCP, PROTO_UDP});

  always_comb begin
    match = 1'b1;
    if (!rd_data.wild_mask[WILD_SRC] && rd_data.src_addr != item.src_addr) begin
      match = 1'b0;
    end
    if (!rd_data.wild_mask[WILD_DST] && rd_data.dst_addr != item.dst_addr) begin
      match = 1'b0;
    end
    if (!rd_data.wild_mask[WILD_PROTO] && rd_data.protocol != item.protocol) begin
      match = 1'b0;
    end
    if (!rd_data.wild_mask[WILD_APP] && item.app_tagged &&
        rd_data.app_type != item.app_type) begin
      match = 1'b0;
    end
    if (!rd_data.wild_mask[WILD_SPORT] &&
        !(ports_ok && rd_data.src_port == item.src_port)) begin
      match = 1'b0;
    end
    if (!rd_data.wild_mask[WILD_DPORT] &&
        !(ports_ok && rd_data.dst_port == item.dst_port)) begin
      match = 1'b0;
    end
  end

  always_comb begin
    wr_rule.src_addr  = item.src_addr;
    wr_rule.dst_addr  = item.dst_addr;
    wr_rule.protocol  = item.protocol;
    wr_rule.app_type  = item.app_type;
    wr_rule.src_port  = item.src_port;
    wr_rule.dst_port  = item.dst_port;
    wr_rule.dscp      = item.code_point;
    wr_rule.wild_mask = item.wild_mask;
  end

  assign stat.is_append = (item.cmd == CMD_APPEND);
  assign stat.full      = (count == CNT_W'(RULE_SLOTS));
  assign stat.is_ipv4   = item.is_ipv4;
  assign stat.scan_end  = (ptr >= count);
  assign stat.pending   = rd_vld;
  assign stat.hit       = rd_vld && match;

  // rule memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[count[IDX_W-1:0]] <= wr_rule;
    end
    if (cmd.issue) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
      rd_idx  <= ptr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.write) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load) begin
        ptr <= '0;
      end else if (cmd.issue) begin
        ptr <= ptr + CNT_W'(1);
      end
      rd_vld <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ADDED: begin
          res_status <= ST_ADDED;
          res_dscp   <= '0;
          res_hit    <= 1'b0;
          res_idx    <= count[IDX_W-1:0];
        end
        RES_FULL: begin
          res_status <= ST_FULL;
          res_dscp   <= '0;
          res_hit    <= 1'b0;
          res_idx    <= '0;
        end
        RES_HIT: begin
          res_status <= ST_CLASSIFIED;
          res_dscp   <= rd_data.dscp;
          res_hit    <= 1'b1;
          res_idx    <= rd_idx;
        end
        default: begin
          res_status <= ST_CLASSIFIED;
          res_dscp   <= item.is_ipv4 ? item.code_point : 6'd0;
          res_hit    <= 1'b0;
          res_idx    <= '0;
        end
      endcase
    end
  end

  assign res_idx_ext = EXT_W'(res_idx);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status  <= res_status;
      out_dscp    <= res_dscp;
      out_matched <= res_hit;
      out_index   <= res_idx_ext[3:0];
    end
  end

endmodule

/* sv/wrpc_checker.sv */
module wrpc_checker import wrpc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]             m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_CLASSIFIED || m_tuser == ST_ADDED || m_tuser == ST_FULL))
    else $error("bad status code");

  // rule add and table full carry no dscp and no match
  a_add_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_CLASSIFIED |-> m_tdata[6:0] == 7'd0)
    else $error("nonzero dscp or match on rule add");

  a_nomatch_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_ADDED && !m_tdata[6] |-> m_tdata[10:7] == 4'd0)
    else $error("nonzero index without match");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer taken during work");

endmodule

bind wildcard_rule_packet_classifier_unit wrpc_checker u_wrpc_checker (.*);
